// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each macro checks a property on the
// rising edge of the given clock and is disabled while the active-low reset
// is asserted. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define U8_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define U8_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define U8_ASSERT_IMP(label, clk, rstn, ante, cons)
`define U8_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/u8dec_pkg.sv
`default_nettype none

package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CNT_W  = 2;

    // Payload masks for lead bytes of each sequence length and for
    // continuation bytes.
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [CNT_W-1:0] pending;   // continuation bytes still expected
        logic [CP_W-1:0]  partial;   // payload bits gathered so far
    } u8dec_state_t;

    // One decoded result, with a flag telling whether the byte produced one.
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            truncated;
        logic            last;
    } u8dec_result_t;

endpackage

`default_nettype wire

// File: rtl/u8dec_core.sv
`default_nettype none

// Combinational decode step: one byte plus the current state gives the next
// state and at most one result.
module u8dec_core (
    input  wire logic [u8dec_pkg::BYTE_W-1:0] byte_in,
    input  wire logic                         last_in,
    input  wire u8dec_pkg::u8dec_state_t      state,
    output u8dec_pkg::u8dec_state_t           state_next,
    output u8dec_pkg::u8dec_result_t          result
);

    logic [u8dec_pkg::CNT_W-1:0] need;
    logic [u8dec_pkg::CP_W-1:0]  lead_bits;
    logic [u8dec_pkg::CP_W-1:0]  shifted;
    logic [u8dec_pkg::CNT_W-1:0] pending_dec;

    // Lead byte classification.
    always_comb begin
        need      = '0;
        lead_bits = '0;
        if (byte_in inside {[8'hC0:8'hDF]}) begin
            need      = 2'd1;
            lead_bits = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::LEAD2_MASK);
        end else if (byte_in inside {[8'hE0:8'hEF]}) begin
            need      = 2'd2;
            lead_bits = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::LEAD3_MASK);
        end else if (byte_in inside {[8'hF0:8'hF7]}) begin
            need      = 2'd3;
            lead_bits = u8dec_pkg::CP_W'(byte_in & u8dec_pkg::LEAD4_MASK);
        end
    end

    // Continuation path: append six payload bits, count one byte down.
    assign shifted     = {state.partial[u8dec_pkg::CP_W-7:0],
                          6'(byte_in & u8dec_pkg::CONT_MASK)};
    assign pending_dec = state.pending - 2'd1;

    always_comb begin
        state_next        = state;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.truncated  = 1'b0;
        result.last       = last_in;
        if (state.pending == '0) begin
            if (need == '0) begin
                // Single byte, stray continuation or invalid lead: pass through.
                result.valid      = 1'b1;
                result.code_point = u8dec_pkg::CP_W'(byte_in);
            end else if (last_in) begin
                result.valid     = 1'b1;
                result.truncated = 1'b1;
                state_next       = '0;
            end else begin
                state_next.pending = need;
                state_next.partial = lead_bits;
            end
        end else begin
            if (pending_dec == '0) begin
                result.valid      = 1'b1;
                result.code_point = shifted;
                state_next        = '0;
            end else if (last_in) begin
                result.valid     = 1'b1;
                result.truncated = 1'b1;
                state_next       = '0;
            end else begin
                state_next.pending = pending_dec;
                state_next.partial = shifted;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder.sv
// Streaming UTF-8 decoder. Bytes enter on the s_ channel, one per request,
// with s_tlast on the last byte of a string; decoded 21-bit code points leave
// on the m_ channel, one per completed sequence, with m_tlast on the last
// result of a string and m_tuser set when the string ended inside a multibyte
// sequence (the code point is then zero). Lead bytes of the form 10xxxxxx or
// 11111xxx pass through as their own value; continuation bytes are not
// checked. The block takes one byte every clock cycle while the output side
// keeps up: a byte is captured in the input register, decoded against the
// state register once the output register is free, and its result is loaded
// into the output register at the end of that cycle.
// Backpressure from m_tready reaches s_tready in the same cycle.
`default_nettype none

`include "assert_macros.svh"

module utf8_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input byte stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // string_end
    // Decoded code point stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [0:0]       m_tuser,   // [0] truncated
    output logic             m_tlast    // last_of_run
);

    // Input register stage.
    logic                              in_valid_reg;
    logic [u8dec_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                              in_last_reg;

    // Decoder state.
    u8dec_pkg::u8dec_state_t           state_reg;
    u8dec_pkg::u8dec_state_t           state_next;

    // Output register stage.
    logic                              m_valid_reg;
    logic [u8dec_pkg::CP_W-1:0]        m_cp_reg;
    logic                              m_trunc_reg;
    logic                              m_last_reg;

    u8dec_pkg::u8dec_result_t          result;
    logic                              out_free;
    logic                              advance;

    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle. The byte in the input register is
    // decoded and retired only then, so a pending result is never dropped.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    u8dec_core u_core (
        .byte_in    (in_byte_reg),
        .last_in    (in_last_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            m_cp_reg    <= result.code_point;
            m_trunc_reg <= result.truncated;
            m_last_reg  <= result.last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, m_cp_reg};
    assign m_tuser[0] = m_trunc_reg;
    assign m_tlast    = m_last_reg;

    // A truncated result always carries a zero code point and closes a string.
    `U8_ASSERT_IMP(a_trunc_shape, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata == 24'd0 && m_tlast)
    // Whenever no continuation is expected, the gathered bits are clear.
    `U8_ASSERT_IMP(a_idle_partial, aclk, aresetn, state_reg.pending == '0,
        state_reg.partial == '0)
    // The end of a string always leaves the decoder idle.
    `U8_ASSERT_NEXT(a_end_idle, aclk, aresetn, advance && in_last_reg,
        state_reg.pending == '0)
    // A byte held back by a full output register stays in the input stage.
    `U8_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Lead byte classes: a byte belongs to a class when its bits under the
    // select mask equal the tag. Continuation bytes carry the 10xxxxxx tag.
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD2_SEL  = 8'hE0;
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD3_SEL  = 8'hF0;
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD4_SEL  = 8'hF8;
    localparam logic [u8dec_pkg::BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [u8dec_pkg::BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [u8dec_pkg::BYTE_W-1:0] ASCII_MASK = 8'h7F;

    localparam int PHASE_BYTES = 550;
    localparam int SETTLE_CYCLES = 8;

    // Tracks the decoder state on the byte side and keeps the code points
    // that the accepted bytes must produce, oldest first.
    class code_point_board;
        typedef struct packed {
            logic [u8dec_pkg::CP_W-1:0] code_point;
            logic                       truncated;
            logic                       last;
        } decoded_t;

        decoded_t                    expected_q[$];
        logic [u8dec_pkg::CNT_W-1:0] cont_left;
        logic [u8dec_pkg::CP_W-1:0]  gathered;
        int                          mismatches;

        function new();
            cont_left  = '0;
            gathered   = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Appends one expected code point behind those already waiting.
        function void add_expected(logic [u8dec_pkg::CP_W-1:0] cp, logic trunc,
                                   logic last);
            expected_q.insert(expected_q.size(), {cp, trunc, last});
        endfunction

        // Called for every byte request the decoder accepts.
        function void note_byte(logic [u8dec_pkg::BYTE_W-1:0] b, logic last);
            logic [u8dec_pkg::CNT_W-1:0] need;
            logic [u8dec_pkg::CP_W-1:0]  bits;
            need = '0;
            bits = '0;
            if (cont_left == 0) begin
                if ((b & LEAD2_SEL) == LEAD2_TAG) begin
                    need = 2'd1;
                    bits = u8dec_pkg::CP_W'(b & u8dec_pkg::LEAD2_MASK);
                end else if ((b & LEAD3_SEL) == LEAD3_TAG) begin
                    need = 2'd2;
                    bits = u8dec_pkg::CP_W'(b & u8dec_pkg::LEAD3_MASK);
                end else if ((b & LEAD4_SEL) == LEAD4_TAG) begin
                    need = 2'd3;
                    bits = u8dec_pkg::CP_W'(b & u8dec_pkg::LEAD4_MASK);
                end
                if (need == 0) begin
                    // ASCII, stray continuation or 11111xxx: passes through.
                    add_expected(u8dec_pkg::CP_W'(b), 1'b0, last);
                end else if (last) begin
                    add_expected('0, 1'b1, 1'b1);
                end else begin
                    cont_left = need;
                    gathered  = bits;
                end
            end else begin
                // Any byte is taken as a continuation here, tag or not.
                gathered  = (gathered << 6) | u8dec_pkg::CP_W'(b & u8dec_pkg::CONT_MASK);
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    add_expected(gathered, 1'b0, last);
                    gathered = '0;
                end else if (last) begin
                    add_expected('0, 1'b1, 1'b1);
                    cont_left = '0;
                    gathered  = '0;
                end
            end
        endfunction

        // Called for every code point request the testbench accepts.
        task check_code_point(logic [u8dec_pkg::CP_W-1:0] cp, logic trunc, logic last);
            decoded_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("code point %06h arrived with none expected", cp));
                return;
            end
            want = expected_q.pop_front();
            if (cp !== want.code_point)
                report($sformatf("code_point %06h, expected %06h", cp, want.code_point));
            if (trunc !== want.truncated)
                report($sformatf("truncated %b, expected %b", trunc, want.truncated));
            if (last !== want.last)
                report($sformatf("last_of_run %b, expected %b", last, want.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Idle rates in percent for the byte sender and the code point receiver.
    int send_idle_pct = 13;
    int recv_idle_pct = 86;

    code_point_board board = new();

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // The receiver drops m_tready at random. Its value for the next cycle is
    // set at each rising edge, so the rate takes effect as soon as it changes.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are watched at the rising edge, where every signal still
    // holds the value it had during the cycle that ends there. A byte is
    // noted before any result is checked, so their order cannot matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_code_point(m_tdata[u8dec_pkg::CP_W-1:0], m_tuser[0], m_tlast);
        end
    end

    // Offers one byte and returns at the edge where the request is accepted.
    // s_tvalid stays high on return so that back-to-back bytes need no gap;
    // an idle cycle, if the sender takes one, lowers it first.
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Stops sending and waits until every expected code point has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.outstanding() != 0)
            @(posedge aclk);
    endtask

    // Builds one string of random characters and sends it, with s_tlast on
    // its final byte. Most characters are well formed with random payload;
    // the rest are single noise bytes or leads followed by arbitrary bytes.
    // Some strings lose their tail bytes, which usually cuts the final
    // character short and makes the decoder flag it as truncated.
    task automatic send_random_string(output int sent);
        logic [7:0] bytes_q[$];
        logic [7:0] lead;
        int         n_chars;
        int         kind;
        int         len;
        int         cut;
        n_chars = $urandom_range(1, 10);
        repeat (n_chars) begin
            kind = $urandom_range(99);
            len  = $urandom_range(1, 4);
            if (kind < 12) begin
                bytes_q.insert(bytes_q.size(), 8'($urandom_range(255)));
            end else begin
                case (len)
                    1:       lead = 8'($urandom) & ASCII_MASK;
                    2:       lead = LEAD2_TAG | (8'($urandom) & ~LEAD2_SEL);
                    3:       lead = LEAD3_TAG | (8'($urandom) & ~LEAD3_SEL);
                    default: lead = LEAD4_TAG | (8'($urandom) & ~LEAD4_SEL);
                endcase
                bytes_q.insert(bytes_q.size(), lead);
                repeat (len - 1) begin
                    if (kind < 88)
                        bytes_q.insert(bytes_q.size(),
                                       CONT_TAG | (8'($urandom) & u8dec_pkg::CONT_MASK));
                    else
                        bytes_q.insert(bytes_q.size(), 8'($urandom_range(255)));
                end
            end
        end
        if ($urandom_range(99) < 20) begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && bytes_q.size() > 1) begin
                void'(bytes_q.pop_back());
                cut--;
            end
        end
        sent = bytes_q.size();
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Directed bytes, each as {string_end, in_byte}.
    logic [8:0] directed_bytes[] = '{
        // Smallest ASCII byte, then an ASCII byte that ends a string.
        {1'b0, 8'h00}, {1'b1, 8'h41},
        // Two-byte sequences at the bottom and top of their payload range.
        {1'b0, 8'hC0}, {1'b0, 8'h80},
        {1'b0, 8'hDF}, {1'b0, 8'hBF},
        // Largest three-byte sequence.
        {1'b0, 8'hEF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
        // Smallest four-byte sequence, then the largest one ending a string.
        {1'b0, 8'hF0}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80},
        {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b1, 8'hBF},
        // A stray continuation byte and two 11111xxx bytes pass through.
        {1'b0, 8'h80}, {1'b0, 8'hF8}, {1'b0, 8'hFF},
        // A multibyte lead as the last byte of a string.
        {1'b1, 8'hC3},
        // A string that ends two bytes into a three-byte sequence.
        {1'b0, 8'hE2}, {1'b1, 8'h82},
        // Continuations without the 10xxxxxx tag are used anyway.
        {1'b0, 8'hC3}, {1'b0, 8'h41}, {1'b0, 8'hC3}, {1'b1, 8'hFF}
    };

    initial begin
        int phase;
        int phase_sent;
        int n;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        // Let everything come back before the random part begins.
        drain_results();

        // Phase 0: sender mostly busy, receiver mostly stalled.
        // Phase 1: the other way round. Phase 2: no idling on either side.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                send_random_string(n);
                phase_sent += n;
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.outstanding() != 0)
            board.report($sformatf("%0d code points never arrived", board.outstanding()));
        if (board.mismatches == 0) begin
            $display("utf8_stream_decoder test passed");
        end else begin
            $display("utf8_stream_decoder test failed");
        end
        $finish;
    end

    // Ends the run as failed if it has not finished before the timeout.
    initial begin
        #2_000_000;
        $display("utf8_stream_decoder test failed");
        $finish;
    end

endmodule

`default_nettype wire
